@@ design/tsmd_pkg.sv @@
package tsmd_pkg;

    localparam int unsigned BLOCK_BYTES = 512;
    localparam int unsigned OFS_W       = $clog2(BLOCK_BYTES);
    localparam int unsigned SIZE_W      = 33;
    localparam int unsigned MODE_W      = 12;

    // Header field locations, as byte offsets inside the header block.
    localparam logic [OFS_W-1:0] SIZE_OFS  = OFS_W'(124);
    localparam logic [OFS_W-1:0] SIZE_STOP = OFS_W'(124 + 12);
    localparam logic [OFS_W-1:0] MODE_OFS  = OFS_W'(100);
    localparam logic [OFS_W-1:0] MODE_STOP = OFS_W'(100 + 8);
    localparam logic [OFS_W-1:0] TYPE_OFS  = OFS_W'(156);
    localparam logic [OFS_W-1:0] LAST_OFS  = OFS_W'(BLOCK_BYTES - 1);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] TYPE_PAXX = 8'h78;
    localparam logic [7:0] TYPE_PAXG = 8'h67;
    localparam logic [7:0] TYPE_LNAM = 8'h4C;
    localparam logic [7:0] TYPE_LLNK = 8'h4B;

    localparam logic [2:0] KIND_HEADER  = 3'd0;
    localparam logic [2:0] KIND_MEMBER  = 3'd1;
    localparam logic [2:0] KIND_PAX     = 3'd2;
    localparam logic [2:0] KIND_LNAME   = 3'd3;
    localparam logic [2:0] KIND_LLINK   = 3'd4;
    localparam logic [2:0] KIND_PAD     = 3'd5;
    localparam logic [2:0] KIND_AFTER   = 3'd6;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_PAD,
        PH_END
    } t_phase;

    typedef enum logic [1:0] {
        OCT_SKIP,
        OCT_DIGITS,
        OCT_DONE
    } t_oct_stage;

    typedef struct packed {
        t_oct_stage        stage;
        logic [SIZE_W-1:0] acc;
    } t_oct_result;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [MODE_W-1:0] mode;
        logic [7:0]        type_byte;
        logic              all_zero;
    } t_hdr_info;

    // One byte of an octal field: leading blanks are skipped, digits shift in,
    // and anything else ends the field.
    function automatic t_oct_result octal_step(t_oct_stage stage,
                                               logic [SIZE_W-1:0] acc,
                                               logic [7:0] b);
        t_oct_result res;
        logic        digit;
        digit     = (b >= CH_ZERO) && (b <= CH_SEVEN);
        res.stage = stage;
        res.acc   = acc;
        unique case (stage)
            OCT_SKIP: begin
                if (b == CH_SPACE || b == CH_NUL) begin
                    res.stage = OCT_SKIP;
                end else if (!digit) begin
                    res.stage = OCT_DONE;
                end else begin
                    res.stage = OCT_DIGITS;
                    res.acc   = {acc[SIZE_W-4:0], b[2:0]};
                end
            end
            OCT_DIGITS: begin
                if (!digit) begin
                    res.stage = OCT_DONE;
                end else begin
                    res.acc = {acc[SIZE_W-4:0], b[2:0]};
                end
            end
            default: begin
                res.stage = stage;
            end
        endcase
        return res;
    endfunction

endpackage

@@ design/tsmd_header_parser.sv @@
// Collects size, mode, type and the all-zero flag over the bytes of a header.
module tsmd_header_parser (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_hdr_beat,
    input  logic [7:0]                          i_data_byte,
    input  logic [tsmd_pkg::OFS_W-1:0]          i_block_offset,
    output tsmd_pkg::t_hdr_info                 o_next,
    output tsmd_pkg::t_hdr_info                 o_held
);

    tsmd_pkg::t_hdr_info   r_info, n_info, base_info;
    tsmd_pkg::t_oct_stage  r_size_stage, n_size_stage, base_size_stage;
    tsmd_pkg::t_oct_stage  r_mode_stage, n_mode_stage, base_mode_stage;
    tsmd_pkg::t_oct_result size_res, mode_res;
    logic                  first_byte;

    assign first_byte = (i_block_offset == '0);

    always_comb begin
        // A new header starts from cleared fields.
        if (first_byte) begin
            base_info       = '{size: '0, mode: '0, type_byte: '0, all_zero: 1'b1};
            base_size_stage = tsmd_pkg::OCT_SKIP;
            base_mode_stage = tsmd_pkg::OCT_SKIP;
        end else begin
            base_info       = r_info;
            base_size_stage = r_size_stage;
            base_mode_stage = r_mode_stage;
        end

        size_res = tsmd_pkg::octal_step(base_size_stage, base_info.size, i_data_byte);
        mode_res = tsmd_pkg::octal_step(base_mode_stage,
                                        tsmd_pkg::SIZE_W'(base_info.mode), i_data_byte);

        n_info       = base_info;
        n_size_stage = base_size_stage;
        n_mode_stage = base_mode_stage;

        if (i_data_byte != tsmd_pkg::CH_NUL) begin
            n_info.all_zero = 1'b0;
        end
        if (i_block_offset >= tsmd_pkg::SIZE_OFS && i_block_offset < tsmd_pkg::SIZE_STOP) begin
            n_info.size  = size_res.acc;
            n_size_stage = size_res.stage;
        end
        if (i_block_offset >= tsmd_pkg::MODE_OFS && i_block_offset < tsmd_pkg::MODE_STOP) begin
            n_info.mode  = mode_res.acc[tsmd_pkg::MODE_W-1:0];
            n_mode_stage = mode_res.stage;
        end
        if (i_block_offset == tsmd_pkg::TYPE_OFS) begin
            n_info.type_byte = i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_info       <= '{size: '0, mode: '0, type_byte: '0, all_zero: 1'b1};
            r_size_stage <= tsmd_pkg::OCT_SKIP;
            r_mode_stage <= tsmd_pkg::OCT_SKIP;
        end else if (i_hdr_beat) begin
            r_info       <= n_info;
            r_size_stage <= n_size_stage;
            r_mode_stage <= n_mode_stage;
        end
    end

    assign o_next = n_info;
    assign o_held = r_info;

endmodule

@@ design/tar_stream_member_deframer_unit.sv @@
// Tar stream deframer. Decompressed tar bytes enter one beat per cycle on the
// input channel and leave, one result beat each, on the output channel in the
// next cycle, tagged as header, member payload (ordinary, pax, long name or
// long link), padding to the block boundary, or bytes after the end of the
// archive. Each 512-byte header is parsed on the fly: the octal size at offset
// 124 (kept to 33 bits), the octal mode at offset 100 (masked to 07777) and
// the type byte at offset 156, with a NUL type shown as '0'. The parsed
// member fields appear on the last header beat and on every payload and
// padding beat of that member; on the other header beats they read zero.
// A header that is entirely zero is flagged on its last beat, and a second
// such header in a row raises archive_end, after which every byte passes
// through as after-end until reset. Throughput is one beat per cycle, set by
// the single registered pass from the input handshake to the output register;
// the input stays ready while a result waits as long as the consumer takes it
// in the same cycle. A truncated stream is not detected.
module tar_stream_member_deframer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_data_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [7:0]                    o_byte_out,
    output logic [2:0]                    o_byte_kind,
    output logic                          o_header_end,
    output logic                          o_header_is_zero,
    output logic [tsmd_pkg::SIZE_W-1:0]   o_member_size,
    output logic [tsmd_pkg::MODE_W-1:0]   o_member_mode,
    output logic [7:0]                    o_member_type,
    output logic                          o_payload_end,
    output logic                          o_archive_end
);

    tsmd_pkg::t_phase              r_phase, n_phase;
    logic [tsmd_pkg::OFS_W-1:0]    r_block_offset, n_block_offset;
    logic [tsmd_pkg::SIZE_W-1:0]   r_payload_left, n_payload_left;
    logic [tsmd_pkg::OFS_W-1:0]    r_pad_left, n_pad_left;
    logic [1:0]                    r_zero_seen, n_zero_seen;

    logic                          r_out_valid;
    logic [7:0]                    r_byte_out;
    logic [2:0]                    r_kind, n_kind;
    logic                          r_hend, n_hend;
    logic                          r_hzero, n_hzero;
    logic [tsmd_pkg::SIZE_W-1:0]   r_msize, n_msize;
    logic [tsmd_pkg::MODE_W-1:0]   r_mmode, n_mmode;
    logic [7:0]                    r_mtype, n_mtype;
    logic                          r_pend, n_pend;
    logic                          r_aend, n_aend;

    logic                          accept;
    logic                          hdr_beat;
    logic                          last_hdr_byte;
    logic [1:0]                    zero_seen_inc;
    logic [tsmd_pkg::OFS_W-1:0]    hdr_pad;
    logic [2:0]                    payload_kind;
    logic [7:0]                    held_type;
    logic [7:0]                    next_type;
    tsmd_pkg::t_hdr_info           hdr_next;
    tsmd_pkg::t_hdr_info           hdr_held;

    // The output register frees itself when the consumer takes its beat, so
    // a new beat can enter in that same cycle.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign hdr_beat   = accept && (r_phase == tsmd_pkg::PH_HEADER);

    tsmd_header_parser u_hdr (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_hdr_beat     (hdr_beat),
        .i_data_byte    (i_data_byte),
        .i_block_offset (r_block_offset),
        .o_next         (hdr_next),
        .o_held         (hdr_held)
    );

    assign last_hdr_byte = (r_block_offset == tsmd_pkg::LAST_OFS);
    assign zero_seen_inc = r_zero_seen + 2'd1;
    // Padding fills the member out to a whole number of blocks.
    assign hdr_pad       = tsmd_pkg::OFS_W'(-hdr_next.size[tsmd_pkg::OFS_W-1:0]);

    assign held_type = (hdr_held.type_byte == tsmd_pkg::CH_NUL) ? tsmd_pkg::CH_ZERO
                                                                : hdr_held.type_byte;
    assign next_type = (hdr_next.type_byte == tsmd_pkg::CH_NUL) ? tsmd_pkg::CH_ZERO
                                                                : hdr_next.type_byte;

    always_comb begin
        priority if (hdr_held.type_byte == tsmd_pkg::TYPE_PAXX ||
                     hdr_held.type_byte == tsmd_pkg::TYPE_PAXG) begin
            payload_kind = tsmd_pkg::KIND_PAX;
        end else if (hdr_held.type_byte == tsmd_pkg::TYPE_LNAM) begin
            payload_kind = tsmd_pkg::KIND_LNAME;
        end else if (hdr_held.type_byte == tsmd_pkg::TYPE_LLNK) begin
            payload_kind = tsmd_pkg::KIND_LLINK;
        end else begin
            payload_kind = tsmd_pkg::KIND_MEMBER;
        end
    end

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            tsmd_pkg::PH_HEADER: begin
                if (last_hdr_byte) begin
                    if (hdr_next.all_zero) begin
                        if (zero_seen_inc >= 2'd2) begin
                            n_phase = tsmd_pkg::PH_END;
                        end
                    end else if (hdr_next.size != '0) begin
                        n_phase = tsmd_pkg::PH_PAYLOAD;
                    end else if (hdr_pad != '0) begin
                        n_phase = tsmd_pkg::PH_PAD;
                    end
                end
            end
            tsmd_pkg::PH_PAYLOAD: begin
                if (r_payload_left <= tsmd_pkg::SIZE_W'(1)) begin
                    n_phase = (r_pad_left != '0) ? tsmd_pkg::PH_PAD : tsmd_pkg::PH_HEADER;
                end
            end
            tsmd_pkg::PH_PAD: begin
                if (r_pad_left <= tsmd_pkg::OFS_W'(1)) begin
                    n_phase = tsmd_pkg::PH_HEADER;
                end
            end
            default: begin
                n_phase = tsmd_pkg::PH_END;
            end
        endcase
    end

    // Result fields and counters.
    always_comb begin
        n_block_offset = r_block_offset;
        n_payload_left = r_payload_left;
        n_pad_left     = r_pad_left;
        n_zero_seen    = r_zero_seen;
        n_kind         = tsmd_pkg::KIND_HEADER;
        n_hend         = 1'b0;
        n_hzero        = 1'b0;
        n_msize        = '0;
        n_mmode        = '0;
        n_mtype        = '0;
        n_pend         = 1'b0;
        n_aend         = 1'b0;
        unique case (r_phase)
            tsmd_pkg::PH_HEADER: begin
                if (last_hdr_byte) begin
                    n_block_offset = '0;
                    n_hend         = 1'b1;
                    if (hdr_next.all_zero) begin
                        n_hzero     = 1'b1;
                        n_mtype     = tsmd_pkg::CH_ZERO;
                        n_zero_seen = zero_seen_inc;
                        n_aend      = (zero_seen_inc >= 2'd2);
                    end else begin
                        n_zero_seen    = '0;
                        n_msize        = hdr_next.size;
                        n_mmode        = hdr_next.mode;
                        n_mtype        = next_type;
                        n_payload_left = hdr_next.size;
                        n_pad_left     = hdr_pad;
                    end
                end else begin
                    n_block_offset = r_block_offset + tsmd_pkg::OFS_W'(1);
                end
            end
            tsmd_pkg::PH_PAYLOAD: begin
                n_kind  = payload_kind;
                n_msize = hdr_held.size;
                n_mmode = hdr_held.mode;
                n_mtype = held_type;
                if (r_payload_left <= tsmd_pkg::SIZE_W'(1)) begin
                    n_payload_left = '0;
                    n_pend         = 1'b1;
                end else begin
                    n_payload_left = r_payload_left - tsmd_pkg::SIZE_W'(1);
                end
            end
            tsmd_pkg::PH_PAD: begin
                n_kind  = tsmd_pkg::KIND_PAD;
                n_msize = hdr_held.size;
                n_mmode = hdr_held.mode;
                n_mtype = held_type;
                if (r_pad_left <= tsmd_pkg::OFS_W'(1)) begin
                    n_pad_left = '0;
                end else begin
                    n_pad_left = r_pad_left - tsmd_pkg::OFS_W'(1);
                end
            end
            default: begin
                n_kind = tsmd_pkg::KIND_AFTER;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= tsmd_pkg::PH_HEADER;
            r_block_offset <= '0;
            r_payload_left <= '0;
            r_pad_left     <= '0;
            r_zero_seen    <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (accept) begin
                r_phase        <= n_phase;
                r_block_offset <= n_block_offset;
                r_payload_left <= n_payload_left;
                r_pad_left     <= n_pad_left;
                r_zero_seen    <= n_zero_seen;
                r_out_valid    <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    // Result payload needs no reset; it is qualified by the valid flag.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte_out <= i_data_byte;
            r_kind     <= n_kind;
            r_hend     <= n_hend;
            r_hzero    <= n_hzero;
            r_msize    <= n_msize;
            r_mmode    <= n_mmode;
            r_mtype    <= n_mtype;
            r_pend     <= n_pend;
            r_aend     <= n_aend;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_byte_out       = r_byte_out;
    assign o_byte_kind      = r_kind;
    assign o_header_end     = r_hend;
    assign o_header_is_zero = r_hzero;
    assign o_member_size    = r_msize;
    assign o_member_mode    = r_mmode;
    assign o_member_type    = r_mtype;
    assign o_payload_end    = r_pend;
    assign o_archive_end    = r_aend;

    // The end of the archive can only be reached from a zero header.
    a_aend_zero_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_archive_end |-> o_header_end && o_header_is_zero)
        else $error("archive end without a zero header");

    // Header end is only reported on header beats.
    a_hend_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_header_end |-> o_byte_kind == tsmd_pkg::KIND_HEADER)
        else $error("header end on a non-header beat");

    // Payload end only marks payload beats.
    a_pend_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_payload_end |->
            (o_byte_kind == tsmd_pkg::KIND_MEMBER || o_byte_kind == tsmd_pkg::KIND_PAX ||
             o_byte_kind == tsmd_pkg::KIND_LNAME || o_byte_kind == tsmd_pkg::KIND_LLINK))
        else $error("payload end on a non-payload beat");

    // Once the archive has ended, the phase never leaves the end state.
    a_end_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == tsmd_pkg::PH_END |=> r_phase == tsmd_pkg::PH_END)
        else $error("left the end phase without reset");

endmodule

@@ test/tar_stream_member_deframer_unit_tb.sv @@
package tsmd_tb_pkg;

    localparam logic [7:0] TYPE_SYMLINK = 8'h32;
    localparam logic [7:0] TYPE_DIR     = 8'h35;
    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_EIGHT     = 8'h38;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;

    // How a number is laid out inside an octal header field.
    typedef enum int {
        FMT_ZERO_PAD,
        FMT_BLANK_PAD,
        FMT_FULL,
        FMT_ODD_END
    } t_octal_fmt;

    typedef struct packed {
        logic [7:0]                  data;
        logic [2:0]                  kind;
        logic                        hdr_end;
        logic                        hdr_zero;
        logic [tsmd_pkg::SIZE_W-1:0] size;
        logic [tsmd_pkg::MODE_W-1:0] mode;
        logic [7:0]                  mtype;
        logic                        pay_end;
        logic                        arc_end;
    } t_tar_beat;

    class tar_frame_checker;
        tsmd_pkg::t_phase            phase;
        logic [tsmd_pkg::OFS_W-1:0]  ofs;
        logic [tsmd_pkg::SIZE_W-1:0] left;
        logic [tsmd_pkg::OFS_W-1:0]  pad;
        logic [tsmd_pkg::SIZE_W-1:0] size_acc;
        logic [tsmd_pkg::MODE_W-1:0] mode_acc;
        tsmd_pkg::t_oct_stage        size_stage;
        tsmd_pkg::t_oct_stage        mode_stage;
        logic [7:0]                  type_code;
        logic                        blank_so_far;
        logic [1:0]                  zero_run;
        t_tar_beat                   due_beats[$];
        int                          errors;
        int                          beats_seen;

        function new();
            phase      = tsmd_pkg::PH_HEADER;
            ofs        = '0;
            left       = '0;
            pad        = '0;
            zero_run   = '0;
            errors     = 0;
            beats_seen = 0;
            start_header();
        endfunction

        function void start_header();
            size_acc     = '0;
            mode_acc     = '0;
            size_stage   = tsmd_pkg::OCT_SKIP;
            mode_stage   = tsmd_pkg::OCT_SKIP;
            type_code    = tsmd_pkg::CH_NUL;
            blank_so_far = 1'b1;
        endfunction

        function void octal_shift(inout tsmd_pkg::t_oct_stage st,
                                  inout logic [tsmd_pkg::SIZE_W-1:0] acc,
                                  input logic [7:0] c);
            logic is_digit;
            is_digit = c inside {[tsmd_pkg::CH_ZERO:tsmd_pkg::CH_SEVEN]};
            case (st)
                tsmd_pkg::OCT_SKIP: begin
                    if (is_digit) begin
                        st  = tsmd_pkg::OCT_DIGITS;
                        acc = (acc << 3) | tsmd_pkg::SIZE_W'(c[2:0]);
                    end else if (c != tsmd_pkg::CH_SPACE && c != tsmd_pkg::CH_NUL) begin
                        st = tsmd_pkg::OCT_DONE;
                    end
                end
                tsmd_pkg::OCT_DIGITS: begin
                    if (is_digit) acc = (acc << 3) | tsmd_pkg::SIZE_W'(c[2:0]);
                    else st = tsmd_pkg::OCT_DONE;
                end
                default: begin
                end
            endcase
        endfunction

        function logic [2:0] payload_kind();
            if (type_code == tsmd_pkg::TYPE_PAXX || type_code == tsmd_pkg::TYPE_PAXG) begin
                return tsmd_pkg::KIND_PAX;
            end
            if (type_code == tsmd_pkg::TYPE_LNAM) return tsmd_pkg::KIND_LNAME;
            if (type_code == tsmd_pkg::TYPE_LLNK) return tsmd_pkg::KIND_LLINK;
            return tsmd_pkg::KIND_MEMBER;
        endfunction

        function void member_fields(inout t_tar_beat e);
            e.size  = size_acc;
            e.mode  = mode_acc;
            e.mtype = (type_code == tsmd_pkg::CH_NUL) ? tsmd_pkg::CH_ZERO : type_code;
        endfunction

        // Advances the framing state by one accepted byte and queues the beat it yields.
        function void frame_byte(logic [7:0] b);
            t_tar_beat                   e;
            logic [tsmd_pkg::SIZE_W-1:0] m;
            e      = '0;
            e.data = b;
            case (phase)
                tsmd_pkg::PH_HEADER: begin
                    if (ofs == '0) start_header();
                    if (b != tsmd_pkg::CH_NUL) blank_so_far = 1'b0;
                    if (ofs >= tsmd_pkg::SIZE_OFS && ofs < tsmd_pkg::SIZE_STOP) begin
                        octal_shift(size_stage, size_acc, b);
                    end
                    if (ofs >= tsmd_pkg::MODE_OFS && ofs < tsmd_pkg::MODE_STOP) begin
                        m = tsmd_pkg::SIZE_W'(mode_acc);
                        octal_shift(mode_stage, m, b);
                        mode_acc = m[tsmd_pkg::MODE_W-1:0];
                    end
                    if (ofs == tsmd_pkg::TYPE_OFS) type_code = b;
                    e.kind = tsmd_pkg::KIND_HEADER;
                    if (ofs == tsmd_pkg::LAST_OFS) begin
                        ofs       = '0;
                        e.hdr_end = 1'b1;
                        if (blank_so_far) begin
                            e.hdr_zero = 1'b1;
                            e.mtype    = tsmd_pkg::CH_ZERO;
                            zero_run   = zero_run + 2'd1;
                            if (zero_run >= 2'd2) begin
                                e.arc_end = 1'b1;
                                phase     = tsmd_pkg::PH_END;
                            end
                        end else begin
                            zero_run = '0;
                            member_fields(e);
                            left = size_acc;
                            pad  = -size_acc[tsmd_pkg::OFS_W-1:0];
                            if (left != '0) phase = tsmd_pkg::PH_PAYLOAD;
                            else if (pad != '0) phase = tsmd_pkg::PH_PAD;
                        end
                    end else begin
                        ofs = ofs + 1'b1;
                    end
                end
                tsmd_pkg::PH_PAYLOAD: begin
                    e.kind = payload_kind();
                    member_fields(e);
                    if (left <= 1) begin
                        left      = '0;
                        e.pay_end = 1'b1;
                        phase     = (pad != '0) ? tsmd_pkg::PH_PAD : tsmd_pkg::PH_HEADER;
                    end else begin
                        left = left - 1'b1;
                    end
                end
                tsmd_pkg::PH_PAD: begin
                    e.kind = tsmd_pkg::KIND_PAD;
                    member_fields(e);
                    if (pad <= 1) begin
                        pad   = '0;
                        phase = tsmd_pkg::PH_HEADER;
                    end else begin
                        pad = pad - 1'b1;
                    end
                end
                default: begin
                    e.kind = tsmd_pkg::KIND_AFTER;
                end
            endcase
            due_beats.push_back(e);
        endfunction

        function bit at_block_start();
            return phase == tsmd_pkg::PH_HEADER && ofs == '0;
        endfunction

        function int pending();
            return due_beats.size();
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH %s", msg);
        endtask

        task cmp_field(string name, logic [tsmd_pkg::SIZE_W-1:0] got,
                       logic [tsmd_pkg::SIZE_W-1:0] want);
            if (got !== want) begin
                report($sformatf("beat %0d %s: got 0x%0h, expected 0x%0h",
                                 beats_seen, name, got, want));
            end
        endtask

        task check_beat(t_tar_beat got);
            t_tar_beat want;
            beats_seen++;
            if (due_beats.size() == 0) begin
                report($sformatf("beat %0d arrived with nothing expected", beats_seen));
            end else begin
                want = due_beats.pop_front();
                cmp_field("byte_out", tsmd_pkg::SIZE_W'(got.data),
                          tsmd_pkg::SIZE_W'(want.data));
                cmp_field("byte_kind", tsmd_pkg::SIZE_W'(got.kind),
                          tsmd_pkg::SIZE_W'(want.kind));
                cmp_field("header_end", tsmd_pkg::SIZE_W'(got.hdr_end),
                          tsmd_pkg::SIZE_W'(want.hdr_end));
                cmp_field("header_is_zero", tsmd_pkg::SIZE_W'(got.hdr_zero),
                          tsmd_pkg::SIZE_W'(want.hdr_zero));
                cmp_field("member_size", got.size, want.size);
                cmp_field("member_mode", tsmd_pkg::SIZE_W'(got.mode),
                          tsmd_pkg::SIZE_W'(want.mode));
                cmp_field("member_type", tsmd_pkg::SIZE_W'(got.mtype),
                          tsmd_pkg::SIZE_W'(want.mtype));
                cmp_field("payload_end", tsmd_pkg::SIZE_W'(got.pay_end),
                          tsmd_pkg::SIZE_W'(want.pay_end));
                cmp_field("archive_end", tsmd_pkg::SIZE_W'(got.arc_end),
                          tsmd_pkg::SIZE_W'(want.arc_end));
            end
        endtask
    endclass

endpackage

module tar_stream_member_deframer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Total number of bytes sent; the stream simply stops there.
    localparam int ITEMS       = 1550;
    localparam int IDLE_PCT    = 10;
    localparam int CYCLE_LIMIT = 20_000;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    logic [7:0]                    i_data_byte = 8'h00;
    logic                          i_out_ready = 1'b0;
    logic                          o_in_ready;
    logic                          o_out_valid;
    logic [7:0]                    o_byte_out;
    logic [2:0]                    o_byte_kind;
    logic                          o_header_end;
    logic                          o_header_is_zero;
    logic [tsmd_pkg::SIZE_W-1:0]   o_member_size;
    logic [tsmd_pkg::MODE_W-1:0]   o_member_mode;
    logic [7:0]                    o_member_type;
    logic                          o_payload_end;
    logic                          o_archive_end;

    tsmd_tb_pkg::tar_frame_checker frames;
    // Staging buffer for the header block that is sent next.
    logic [7:0]                    hdr [tsmd_pkg::BLOCK_BYTES];
    // While set, neither side inserts idle cycles.
    logic                          steady     = 1'b0;
    int                            sent_bytes = 0;
    int                            cycles     = 0;

    tar_stream_member_deframer_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_byte_out       (o_byte_out),
        .o_byte_kind      (o_byte_kind),
        .o_header_end     (o_header_end),
        .o_header_is_zero (o_header_is_zero),
        .o_member_size    (o_member_size),
        .o_member_mode    (o_member_mode),
        .o_member_type    (o_member_type),
        .o_payload_end    (o_payload_end),
        .o_archive_end    (o_archive_end)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop: a hung handshake or a lost result beat ends the run here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[tar_stream_member_deframer_unit] ERROR");
            $finish;
        end
    end

    // Result side. Values are sampled as they stood before the edge, so a beat
    // counts exactly when valid and ready were both high going into it. Ready
    // then drops at random with a ten percent chance, except during steady stretches.
    always @(posedge i_clk) begin
        tsmd_tb_pkg::t_tar_beat got;
        if (o_out_valid && i_out_ready) begin
            got.data     = o_byte_out;
            got.kind     = o_byte_kind;
            got.hdr_end  = o_header_end;
            got.hdr_zero = o_header_is_zero;
            got.size     = o_member_size;
            got.mode     = o_member_mode;
            got.mtype    = o_member_type;
            got.pay_end  = o_payload_end;
            got.arc_end  = o_archive_end;
            frames.check_beat(got);
        end
        i_out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Sends one byte. It is called at a rising edge and returns at the edge that
    // accepted the beat, with valid still high. A gap, when one is taken, lowers
    // valid first, so valid never gets two assignments in one time step.
    task automatic send_byte(input logic [7:0] b);
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 40);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        frames.frame_byte(b);
        sent_bytes++;
    endtask

    task automatic send_block();
        for (int i = 0; i < tsmd_pkg::BLOCK_BYTES; i++) send_byte(hdr[i]);
    endtask

    task automatic zero_block();
        for (int i = 0; i < tsmd_pkg::BLOCK_BYTES; i++) hdr[i] = tsmd_pkg::CH_NUL;
    endtask

    task automatic fill_random_header();
        for (int i = 0; i < tsmd_pkg::BLOCK_BYTES; i++) hdr[i] = 8'($urandom_range(255));
    endtask

    // Payload and padding content does not matter to the block, so random
    // bytes go out until the tracked framing is back at a header boundary.
    task automatic finish_member();
        while (!frames.at_block_start()) send_byte(8'($urandom_range(255)));
    endtask

    // Writes a number into an octal header field in one of several layouts:
    // zero padded with a blank or NUL terminator, padded on the left with a
    // mix of spaces and NULs, digits filling the whole field with no
    // terminator, or digits ended by a byte that is neither octal nor blank.
    task automatic put_octal(int ofs, int len, longint unsigned v,
                             tsmd_tb_pkg::t_octal_fmt fmt);
        int unsigned digs [12];
        int          nd;
        int          lead;
        logic [7:0]  odd_ends [4];
        odd_ends = '{tsmd_tb_pkg::CH_EIGHT, tsmd_tb_pkg::CH_NINE, tsmd_tb_pkg::CH_HASH,
                     tsmd_tb_pkg::CH_UPPER_A};
        nd = 0;
        do begin
            digs[nd] = 32'(v % 8);
            v        = v / 8;
            nd++;
        end while (v != 0 && nd < 12);
        case (fmt)
            tsmd_tb_pkg::FMT_FULL:    lead = len - nd;
            tsmd_tb_pkg::FMT_ODD_END: lead = 0;
            default:                  lead = len - 1 - nd;
        endcase
        if (lead < 0) lead = 0;
        for (int k = 0; k < lead; k++) begin
            if (fmt == tsmd_tb_pkg::FMT_BLANK_PAD) begin
                hdr[ofs+k] = $urandom_range(1) ? tsmd_pkg::CH_SPACE : tsmd_pkg::CH_NUL;
            end else begin
                hdr[ofs+k] = tsmd_pkg::CH_ZERO;
            end
        end
        for (int k = 0; k < nd; k++) hdr[ofs+lead+k] = tsmd_pkg::CH_ZERO + 8'(digs[nd-1-k]);
        if (lead + nd < len) begin
            if (fmt == tsmd_tb_pkg::FMT_ODD_END) begin
                hdr[ofs+lead+nd] = odd_ends[$urandom_range(3)];
            end else begin
                hdr[ofs+lead+nd] = $urandom_range(1) ? tsmd_pkg::CH_SPACE : tsmd_pkg::CH_NUL;
            end
        end
    endtask

    function automatic logic [7:0] pick_type();
        case ($urandom_range(8))
            0:       return tsmd_pkg::CH_ZERO;
            1:       return tsmd_pkg::CH_NUL;
            2:       return tsmd_pkg::TYPE_PAXX;
            3:       return tsmd_pkg::TYPE_PAXG;
            4:       return tsmd_pkg::TYPE_LNAM;
            5:       return tsmd_pkg::TYPE_LLNK;
            6:       return tsmd_tb_pkg::TYPE_DIR;
            7:       return tsmd_tb_pkg::TYPE_SYMLINK;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Holds the sender off until every expected beat has come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (frames.pending() != 0);
    endtask

    initial begin
        frames = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // One member with a short payload and its padding. The mode may carry
        // bits above 07777 that must be dropped.
        fill_random_header();
        put_octal(int'(tsmd_pkg::SIZE_OFS), 12, longint'($urandom_range(40, 1)),
                  tsmd_tb_pkg::t_octal_fmt'($urandom_range(3)));
        put_octal(int'(tsmd_pkg::MODE_OFS), 8, longint'($urandom_range(2097151)),
                  tsmd_tb_pkg::t_octal_fmt'($urandom_range(3)));
        hdr[tsmd_pkg::TYPE_OFS] = pick_type();
        send_block();
        // The sender waits for every result before the payload goes out.
        drain();
        finish_member();
        // A zero header with both sides running flat out.
        steady = 1'b1;
        zero_block();
        send_block();
        steady = 1'b0;
        // The stream ends partway into the next header.
        fill_random_header();
        for (int i = 0; sent_bytes < ITEMS; i++) send_byte(hdr[i]);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (frames.pending() != 0);
        // Keep clocking so that any stray extra beat is caught.
        repeat (10) @(posedge i_clk);
        if (frames.errors == 0) begin
            $display("[tar_stream_member_deframer_unit] OK");
        end else begin
            $display("[tar_stream_member_deframer_unit] ERROR");
        end
        $finish;
    end

endmodule
